// ----- rtl/core/time_window_range_averager_assert.svh -----
// Assertion macros for the averager
`ifndef TIME_WINDOW_RANGE_AVERAGER_ASSERT_SVH
`define TIME_WINDOW_RANGE_AVERAGER_ASSERT_SVH
// implication checked at every clock edge outside reset
`define TWRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TWRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/twra_pkg.sv -----
package twra_pkg;
    localparam int RING_DEPTH = 2048;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [23:0] VALID_CM = 24'd50;
    localparam logic [31:0] MIN_WINDOW_MS = 32'd750;
    localparam logic [31:0] MIN_SPAN_MS = 32'd250;
    localparam logic [0:0] REG_AVERAGE = 1'b0;
    localparam logic [0:0] REG_BEEP = 1'b1;
    // one stored entry: stamp, three ranges, packed strengths
    typedef struct packed {
        logic [31:0] stamp;
        logic [23:0] r1;
        logic [23:0] r2;
        logic [23:0] r3;
        logic [47:0] s;
    } entry_t;
    // divider request
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [47:0] den;
    } div_req_t;
    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;
endpackage

// ----- rtl/core/time_window_range_averager.sv -----
// Sliding time-window averager, one result per request.
// Each request walks N entries (evicted plus window, up to 2047) through the single read
// port of the ring memory, then runs its divisions one at a time on the shared divider.
// Throughput: one request at a time; no new request is taken until the result is accepted.
// Reset: asynchronous active low; state, ring pointers, held strengths, output valid and
// config registers cleared; ring contents undefined until written, no clearing pass.
module time_window_range_averager (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] stamp_ms,
    input  logic [23:0] range_one,
    input  logic [23:0] range_two,
    input  logic [23:0] range_three,
    input  logic [15:0] strength_one,
    input  logic [15:0] strength_two,
    input  logic [15:0] strength_three,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] shown_range_one,
    output logic [23:0] shown_range_two,
    output logic [23:0] shown_range_three,
    output logic [15:0] shown_strength_one,
    output logic [15:0] shown_strength_two,
    output logic [15:0] shown_strength_three,
    output logic [2:0]  no_average_mask,
    output logic [15:0] rate_tenths_hz,
    output logic        rate_valid,
    output logic        beep_request
);
    import twra_pkg::*;
    `include "time_window_range_averager_assert.svh"

    localparam logic [3:0] S_IDLE = 4'd0, S_WRITE = 4'd1, S_NEWRD = 4'd2,
        S_NEWWT = 4'd3, S_EVRD = 4'd4, S_EVWT = 4'd5, S_SUMRD = 4'd6,
        S_SUMWT = 4'd7, S_DIV = 4'd8, S_DIVWT = 4'd9, S_OUT = 4'd10;

    logic [3:0] st_reg, st_next;
    logic [3:0] avg_reg;
    logic       beep_en_reg;
    logic [IDX_W-1:0] old_reg, old_next, wr_reg, wr_next, cur_reg, cur_next, raddr;
    logic [47:0] held_reg, held_next;
    entry_t      in_reg, rdata;
    logic        we;
    logic [31:0] newest_stamp_reg, newest_stamp_next;
    entry_t      newest_reg, newest_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] span_reg, span_next;
    logic [47:0] dsum_reg [3], dsum_next [3], asum_reg [3], asum_next [3];
    logic [CNT_W-1:0] cnt_reg [3], cnt_next [3];
    logic [2:0]  dsel_reg, dsel_next;
    logic [47:0] res_reg [7], res_next [7];
    logic        beep_reg, beep_next;
    logic        ovalid_reg, ovalid_next;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic [31:0] window_ms, age;
    logic        rate_ok;
    logic [IDX_W-1:0] nxt_wr, old_plus;
    logic [2:0]  hit;

    twra_ring_ram u_ram (.clk(clk), .we(we), .waddr(wr_reg), .wdata(in_reg),
        .raddr(raddr), .rdata(rdata));
    twra_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_ready = (st_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign window_ms = (avg_reg == 4'd0) ? MIN_WINDOW_MS : 32'(avg_reg) * 32'd1000;
    assign nxt_wr = wr_reg + IDX_W'(1);
    assign old_plus = old_reg + IDX_W'(1);
    assign age = newest_stamp_reg - rdata.stamp;
    assign rate_ok = (count_reg > CNT_W'(1)) && (span_reg >= MIN_SPAN_MS);

    function automatic logic [2:0] chan_valid(entry_t e);
        chan_valid = {e.r3 > VALID_CM, e.r2 > VALID_CM, e.r1 > VALID_CM};
    endfunction

    assign hit = chan_valid(rdata);

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        old_next = old_reg;
        wr_next = wr_reg;
        cur_next = cur_reg;
        held_next = held_reg;
        newest_stamp_next = newest_stamp_reg;
        newest_next = newest_reg;
        count_next = count_reg;
        span_next = span_reg;
        dsel_next = dsel_reg;
        beep_next = beep_reg;
        ovalid_next = ovalid_reg;
        we = 1'b0;
        raddr = cur_reg;
        dreq = '0;
        for (int k = 0; k < 3; k++)
        begin
            dsum_next[k] = dsum_reg[k];
            asum_next[k] = asum_reg[k];
            cnt_next[k] = cnt_reg[k];
        end
        for (int k = 0; k < 7; k++)
        begin
            res_next[k] = res_reg[k];
        end
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (st_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    beep_next = beep_en_reg && ((range_one > VALID_CM)
                        || (range_two > VALID_CM) || (range_three > VALID_CM));
                    st_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // store unless full
                if (nxt_wr != old_reg)
                begin
                    we = 1'b1;
                    wr_next = nxt_wr;
                    cur_next = wr_reg;
                end
                else
                begin
                    cur_next = wr_reg - IDX_W'(1);
                end
                st_next = S_NEWRD;
            end
            S_NEWRD:
            begin
                raddr = cur_reg;
                st_next = S_NEWWT;
            end
            S_NEWWT:
            begin
                newest_next = rdata;
                newest_stamp_next = rdata.stamp;
                raddr = old_reg;
                st_next = S_EVWT;
            end
            S_EVRD:
            begin
                raddr = old_reg;
                st_next = S_EVWT;
            end
            S_EVWT:
            begin
                // evict oldest while too old, keep two
                if (old_reg != cur_reg && age > window_ms && old_plus != cur_reg)
                begin
                    old_next = old_plus;
                    st_next = S_EVRD;
                end
                else
                begin
                    count_next = {1'b0, wr_reg - old_reg};
                    if (count_next == '0)
                    begin
                        count_next = CNT_W'(RING_DEPTH);
                    end
                    span_next = (old_reg == cur_reg) ? 32'd0 : age;
                    for (int k = 0; k < 3; k++)
                    begin
                        dsum_next[k] = '0;
                        asum_next[k] = '0;
                        cnt_next[k] = '0;
                    end
                    cur_next = old_reg;
                    if (count_next <= CNT_W'(1) || avg_reg == 4'd0)
                    begin
                        res_next[0] = 48'(newest_reg.r1);
                        res_next[1] = 48'(newest_reg.r2);
                        res_next[2] = 48'(newest_reg.r3);
                        res_next[3] = 48'(newest_reg.s[15:0]);
                        res_next[4] = 48'(newest_reg.s[31:16]);
                        res_next[5] = 48'(newest_reg.s[47:32]);
                        dsel_next = 3'd6;
                    end
                    else
                    begin
                        dsel_next = 3'd0;
                        st_next = S_SUMRD;
                    end
                    if (dsel_next == 3'd6)
                    begin
                        st_next = S_DIV;
                    end
                end
            end
            S_SUMRD:
            begin
                raddr = cur_reg;
                st_next = S_SUMWT;
            end
            S_SUMWT:
            begin
                // accumulate valid channels of one entry
                if (hit[0])
                begin
                    dsum_next[0] = dsum_reg[0] + 48'(rdata.r1);
                    asum_next[0] = asum_reg[0] + 48'(rdata.s[15:0]);
                    cnt_next[0] = cnt_reg[0] + CNT_W'(1);
                end
                if (hit[1])
                begin
                    dsum_next[1] = dsum_reg[1] + 48'(rdata.r2);
                    asum_next[1] = asum_reg[1] + 48'(rdata.s[31:16]);
                    cnt_next[1] = cnt_reg[1] + CNT_W'(1);
                end
                if (hit[2])
                begin
                    dsum_next[2] = dsum_reg[2] + 48'(rdata.r3);
                    asum_next[2] = asum_reg[2] + 48'(rdata.s[47:32]);
                    cnt_next[2] = cnt_reg[2] + CNT_W'(1);
                end
                cur_next = cur_reg + IDX_W'(1);
                st_next = (cur_next == wr_reg) ? S_DIV : S_SUMRD;
            end
            S_DIV:
            begin
                // issue next division: ranges, strengths, then rate
                if (dsel_reg < 3'd3)
                begin
                    if (cnt_reg[dsel_reg[1:0]] == '0)
                    begin
                        res_next[dsel_reg] = '0;
                        res_next[dsel_reg + 3'd3] = 48'(held_reg[16*dsel_reg[1:0] +: 16]);
                        dsel_next = dsel_reg + 3'd1;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.num = {dsum_reg[dsel_reg[1:0]][46:0], 1'b0}
                            + 48'(cnt_reg[dsel_reg[1:0]]);
                        dreq.den = 48'({cnt_reg[dsel_reg[1:0]], 1'b0});
                        st_next = S_DIVWT;
                    end
                end
                else if (dsel_reg < 3'd6)
                begin
                    if (cnt_reg[2'(dsel_reg - 3'd3)] == '0)
                    begin
                        dsel_next = dsel_reg + 3'd1;
                    end
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.num = asum_reg[2'(dsel_reg - 3'd3)];
                        dreq.den = 48'(cnt_reg[2'(dsel_reg - 3'd3)]);
                        st_next = S_DIVWT;
                    end
                end
                else if (rate_ok)
                begin
                    dreq.start = 1'b1;
                    dreq.num = 48'(count_reg - CNT_W'(1)) * 48'd20000 + 48'(span_reg);
                    dreq.den = {15'd0, span_reg, 1'b0};
                    st_next = S_DIVWT;
                end
                else
                begin
                    res_next[6] = '0;
                    st_next = S_OUT;
                end
            end
            S_DIVWT:
            begin
                if (drsp.done)
                begin
                    res_next[dsel_reg] = drsp.quo;
                    if (dsel_reg == 3'd6)
                    begin
                        st_next = S_OUT;
                    end
                    else
                    begin
                        dsel_next = dsel_reg + 3'd1;
                        st_next = S_DIV;
                    end
                end
            end
            S_OUT:
            begin
                held_next = {res_reg[5][15:0], res_reg[4][15:0], res_reg[3][15:0]};
                ovalid_next = 1'b1;
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            old_reg <= '0;
            wr_reg <= '0;
            held_reg <= '0;
            avg_reg <= '0;
            beep_en_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            old_reg <= old_next;
            wr_reg <= wr_next;
            held_reg <= held_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_AVERAGE)
                begin
                    avg_reg <= cfg_data;
                end
                else if (cfg_index == REG_BEEP)
                begin
                    beep_en_reg <= cfg_data[0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= {stamp_ms, range_one, range_two, range_three,
                strength_three, strength_two, strength_one};
        end
        cur_reg <= cur_next;
        newest_reg <= newest_next;
        newest_stamp_reg <= newest_stamp_next;
        count_reg <= count_next;
        span_reg <= span_next;
        dsel_reg <= dsel_next;
        beep_reg <= beep_next;
        for (int k = 0; k < 3; k++)
        begin
            dsum_reg[k] <= dsum_next[k];
            asum_reg[k] <= asum_next[k];
            cnt_reg[k] <= cnt_next[k];
        end
        for (int k = 0; k < 7; k++)
        begin
            res_reg[k] <= res_next[k];
        end
    end

    assign out_valid = ovalid_reg;
    assign shown_range_one = res_reg[0][23:0];
    assign shown_range_two = res_reg[1][23:0];
    assign shown_range_three = res_reg[2][23:0];
    assign shown_strength_one = res_reg[3][15:0];
    assign shown_strength_two = res_reg[4][15:0];
    assign shown_strength_three = res_reg[5][15:0];
    assign no_average_mask = (avg_reg == 4'd0 || count_reg <= CNT_W'(1)) ? 3'd0
        : {cnt_reg[2] == '0, cnt_reg[1] == '0, cnt_reg[0] == '0};
    assign rate_tenths_hz = (res_reg[6] > 48'd65535) ? 16'hFFFF : res_reg[6][15:0];
    assign rate_valid = rate_ok;
    assign beep_request = beep_reg;

    `TWRA_ASSERT_IMP(a_no_accept_busy, st_reg != S_IDLE, !in_ready)
    `TWRA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `TWRA_ASSERT_IMP(a_rate_zero, out_valid && !rate_valid, rate_tenths_hz == 16'd0)
endmodule

// ----- rtl/core/twra_ring_ram.sv -----
module twra_ring_ram (
    input  logic                   clk,
    input  logic                   we,
    input  logic [twra_pkg::IDX_W-1:0] waddr,
    input  twra_pkg::entry_t       wdata,
    input  logic [twra_pkg::IDX_W-1:0] raddr,
    output twra_pkg::entry_t       rdata
);
    import twra_pkg::*;
    entry_t mem [RING_DEPTH];
    // write one entry, read registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/twra_divider.sv -----
module twra_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  twra_pkg::div_req_t req,
    output twra_pkg::div_rsp_t rsp
);
    import twra_pkg::*;
    logic [47:0] rem_reg, rem_next, quo_reg, quo_next, den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [48:0] trial;
    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[47]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.num;
            den_next = req.den;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[48])
            begin
                rem_next = trial[47:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[46:0], quo_reg[47]};
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end
    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
endmodule

// ----- tb/time_window_range_averager_checker.sv -----
module time_window_range_averager_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] stamp_ms,
    input  logic [23:0] range_one,
    input  logic [23:0] range_two,
    input  logic [23:0] range_three,
    input  logic [15:0] strength_one,
    input  logic [15:0] strength_two,
    input  logic [15:0] strength_three,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] shown_range_one,
    input  logic [23:0] shown_range_two,
    input  logic [23:0] shown_range_three,
    input  logic [15:0] shown_strength_one,
    input  logic [15:0] shown_strength_two,
    input  logic [15:0] shown_strength_three,
    input  logic [2:0]  no_average_mask,
    input  logic [15:0] rate_tenths_hz,
    input  logic        rate_valid,
    input  logic        beep_request,
    output int          fail_count,
    output int          pending
);
    import twra_pkg::*;

    typedef struct packed {
        logic [2:0][23:0] rng;
        logic [2:0][15:0] amp;
        logic [2:0]       mask;
        logic [15:0]      rate;
        logic             rate_ok;
        logic             beep;
    } view_t;

    // shadow of the block state
    logic [31:0] stamps [RING_DEPTH];
    logic [23:0] ranges [3][RING_DEPTH];
    logic [15:0] amps [3][RING_DEPTH];
    int          oldest_at;
    int          write_at;
    logic [15:0] held_amp [3];
    logic [3:0]  avg_sec;
    logic        beep_on;

    view_t expected_views [$];

    function automatic int ring_after(int i);
        return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
    endfunction

    // compute the display for one accepted sample and advance the shadow ring
    function automatic view_t predict_view(logic [31:0] st, logic [2:0][23:0] r,
                                           logic [2:0][15:0] s);
        view_t       v;
        int          nxt;
        int          newest;
        int          cnt;
        int          i;
        int          n;
        bit          walking;
        logic [31:0] win;
        logic [31:0] span;
        logic [63:0] q;
        logic [63:0] dsum [3];
        logic [63:0] asum [3];
        int          hits [3];
        v = '0;
        for (int k = 0; k < 3; k++)
            if (r[k] > VALID_CM) v.beep = beep_on;
        nxt = ring_after(write_at);
        if (nxt != oldest_at)
        begin
            stamps[write_at] = st;
            for (int k = 0; k < 3; k++)
            begin
                ranges[k][write_at] = r[k];
                amps[k][write_at] = s[k];
            end
            write_at = nxt;
        end
        newest = (write_at == 0) ? RING_DEPTH - 1 : write_at - 1;
        win = (avg_sec == 0) ? MIN_WINDOW_MS : 32'(avg_sec) * 32'd1000;
        // evict stale entries, keep the newest two
        walking = 1;
        while (walking && oldest_at != newest)
        begin
            if (32'(stamps[newest] - stamps[oldest_at]) <= win)
                walking = 0;
            else
            begin
                n = ring_after(oldest_at);
                if (n == newest)
                    walking = 0;
                else
                    oldest_at = n;
            end
        end
        cnt = (write_at >= oldest_at) ? write_at - oldest_at
                                      : RING_DEPTH - oldest_at + write_at;
        span = stamps[newest] - stamps[oldest_at];
        v.rate_ok = (cnt > 1) && (span >= MIN_SPAN_MS);
        if (v.rate_ok)
        begin
            q = (64'(cnt - 1) * 64'd20000 + 64'(span)) / (64'd2 * 64'(span));
            v.rate = (q > 64'd65535) ? 16'hffff : q[15:0];
        end
        if (cnt <= 1 || avg_sec == 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v.rng[k] = ranges[k][newest];
                v.amp[k] = amps[k][newest];
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                dsum[k] = 0;
                asum[k] = 0;
                hits[k] = 0;
            end
            i = oldest_at;
            while (i != write_at)
            begin
                for (int k = 0; k < 3; k++)
                    if (ranges[k][i] > VALID_CM)
                    begin
                        dsum[k] += ranges[k][i];
                        asum[k] += amps[k][i];
                        hits[k]++;
                    end
                i = ring_after(i);
            end
            for (int k = 0; k < 3; k++)
            begin
                if (hits[k] > 0)
                begin
                    v.rng[k] = 24'((2 * dsum[k] + hits[k]) / (2 * hits[k]));
                    v.amp[k] = 16'(asum[k] / hits[k]);
                end
                else
                begin
                    v.rng[k] = '0;
                    v.amp[k] = held_amp[k];
                    v.mask[k] = 1'b1;
                end
            end
        end
        for (int k = 0; k < 3; k++)
            held_amp[k] = v.amp[k];
        return v;
    endfunction

    task automatic flag_mismatch(string what, view_t want, view_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        view_t got;
        view_t want;
        if (!rst_n)
        begin
            oldest_at = 0;
            write_at = 0;
            for (int k = 0; k < 3; k++)
                held_amp[k] = '0;
            avg_sec = '0;
            beep_on = 1'b0;
            expected_views.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_AVERAGE)
                    avg_sec = cfg_data;
                else if (cfg_index == REG_BEEP)
                    beep_on = cfg_data[0];
            end
            // predict each accepted request
            if (in_valid && in_ready)
                expected_views.push_back(predict_view(stamp_ms,
                    {range_three, range_two, range_one},
                    {strength_three, strength_two, strength_one}));
            // compare each accepted result
            if (out_valid && out_ready)
            begin
                got.rng = {shown_range_three, shown_range_two, shown_range_one};
                got.amp = {shown_strength_three, shown_strength_two, shown_strength_one};
                got.mask = no_average_mask;
                got.rate = rate_tenths_hz;
                got.rate_ok = rate_valid;
                got.beep = beep_request;
                if (expected_views.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_views.pop_front();
                    if (got.rng[0] !== want.rng[0]) flag_mismatch("shown_range_one", want, got);
                    if (got.rng[1] !== want.rng[1]) flag_mismatch("shown_range_two", want, got);
                    if (got.rng[2] !== want.rng[2]) flag_mismatch("shown_range_three", want, got);
                    if (got.amp[0] !== want.amp[0]) flag_mismatch("shown_strength_one", want, got);
                    if (got.amp[1] !== want.amp[1]) flag_mismatch("shown_strength_two", want, got);
                    if (got.amp[2] !== want.amp[2]) flag_mismatch("shown_strength_three", want, got);
                    if (got.mask !== want.mask) flag_mismatch("no_average_mask", want, got);
                    if (got.rate !== want.rate) flag_mismatch("rate_tenths_hz", want, got);
                    if (got.rate_ok !== want.rate_ok) flag_mismatch("rate_valid", want, got);
                    if (got.beep !== want.beep) flag_mismatch("beep_request", want, got);
                end
            end
            pending = expected_views.size();
        end
    end
endmodule

// ----- tb/time_window_range_averager_tb.sv -----
module time_window_range_averager_tb;
    import twra_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 4800;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] stamp_ms;
    logic [23:0] range_one;
    logic [23:0] range_two;
    logic [23:0] range_three;
    logic [15:0] strength_one;
    logic [15:0] strength_two;
    logic [15:0] strength_three;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] shown_range_one;
    logic [23:0] shown_range_two;
    logic [23:0] shown_range_three;
    logic [15:0] shown_strength_one;
    logic [15:0] shown_strength_two;
    logic [15:0] shown_strength_three;
    logic [2:0]  no_average_mask;
    logic [15:0] rate_tenths_hz;
    logic        rate_valid;
    logic        beep_request;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          steady;
    bit          hold_req;
    logic [31:0] clock_ms;

    time_window_range_averager u_top (.*);

    time_window_range_averager_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on demand
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (6000) @(posedge clk);
                hold_req = 0;
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic wait_drained();
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // offer one request; keep valid high across back-to-back requests
    task automatic send_sample(logic [31:0] st, logic [23:0] ra, logic [23:0] rb,
                               logic [23:0] rc, logic [15:0] sa, logic [15:0] sb,
                               logic [15:0] sc);
        if (!steady && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        stamp_ms <= st;
        range_one <= ra;
        range_two <= rb;
        range_three <= rc;
        strength_one <= sa;
        strength_two <= sb;
        strength_three <= sc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] pick_range();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 49));
            1: return VALID_CM;
            2: return VALID_CM + 24'd1;
            3: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // random burst with mostly realistic stamp steps
    task automatic random_burst(int n);
        logic [31:0] step;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0: step = $urandom;
                1, 2: step = $urandom_range(1000, 16000);
                3: step = 0;
                default: step = $urandom_range(1, 400);
            endcase
            clock_ms = clock_ms + step;
            send_sample(clock_ms, pick_range(), pick_range(), pick_range(),
                        16'($urandom), 16'($urandom), 16'($urandom));
        end
        end_burst();
    endtask

    initial
    begin
        logic [3:0] avg_pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        stamp_ms = '0;
        range_one = '0;
        range_two = '0;
        range_three = '0;
        strength_one = '0;
        strength_two = '0;
        strength_three = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_AVERAGE;
        cfg_data = '0;
        steady = 0;
        hold_req = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // averaging off: newest sample shown, field extremes, beep disabled
        send_sample(32'd0, 24'd0, 24'd49, 24'd50, 16'd0, 16'hffff, 16'd0);
        send_sample(32'd100, 24'hffffff, 24'd51, 24'd0, 16'hffff, 16'd0, 16'hffff);
        send_sample(32'd400, 24'd51, 24'd51, 24'd51, 16'h1234, 16'h5678, 16'h9abc);
        send_sample(32'd2000, 24'd60, 24'd0, 24'd0, 16'd7, 16'd8, 16'd9);
        end_burst();

        // beep on via odd data, averaging one second
        write_reg(REG_BEEP, 4'hf);
        write_reg(REG_AVERAGE, 4'd1);
        // newest two entries kept after a long gap, then a window with invalid channels
        send_sample(32'd9000, 24'd49, 24'd50, 24'd200, 16'd10, 16'd20, 16'd30);
        send_sample(32'd9100, 24'd0, 24'd50, 24'd301, 16'd11, 16'd21, 16'd31);
        send_sample(32'd9300, 24'd100, 24'd10, 24'd302, 16'd12, 16'd22, 16'd32);
        send_sample(32'd9600, 24'd101, 24'd0, 24'd0, 16'hffff, 16'd23, 16'd33);
        send_sample(32'd9900, 24'hffffff, 24'hffffff, 24'hffffff, 16'hffff, 16'hffff, 16'hffff);
        send_sample(32'd12000, 24'd0, 24'd0, 24'd0, 16'd1, 16'd2, 16'd3);
        send_sample(32'd12000, 24'd40, 24'd40, 24'd40, 16'd1, 16'd2, 16'd3);
        end_burst();

        // longest window, stamps wrapping through zero
        write_reg(REG_AVERAGE, 4'd15);
        send_sample(32'hffffff00, 24'd500, 24'd600, 24'd700, 16'd100, 16'd200, 16'd300);
        send_sample(32'hffffffff, 24'd501, 24'd601, 24'd701, 16'd101, 16'd201, 16'd301);
        send_sample(32'h00000080, 24'd502, 24'd602, 24'd702, 16'd102, 16'd202, 16'd302);
        send_sample(32'h00003000, 24'd503, 24'd0, 24'd703, 16'd103, 16'd203, 16'd303);
        send_sample(32'h00100000, 24'd504, 24'd604, 24'd704, 16'd104, 16'd204, 16'd304);
        end_burst();

        // random phases over a spread of settings
        clock_ms = $urandom;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: avg_pick = 4'd0;
                1: avg_pick = 4'd10;
                2: avg_pick = 4'd15;
                3: avg_pick = 4'd1;
                default: avg_pick = 4'($urandom_range(0, 15));
            endcase
            write_reg(REG_AVERAGE, avg_pick);
            write_reg(REG_BEEP, 4'($urandom));
            steady = (phase == 3);
            if (phase == 2)
                hold_req = 1;
            random_burst(18);
        end
        steady = 0;

        // drain, let the block settle, then judge
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
